// File: src/osse_pkg.sv
// Shared types and constants for the ordered set successor engine.
package osse_pkg;

  localparam int unsigned KeyW = 32;

  // Operation codes carried by the kind field of an item.
  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_EXISTS = 3'd2,
    KIND_SUCC   = 3'd3,
    KIND_PRED   = 3'd4
  } kind_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                   capture;  // compare flags are taken this cycle
    logic signed [KeyW-1:0] cmp_key;  // key compared against at capture
    logic                   ins;      // open a slot and write upd_key
    logic                   del;      // close the slot of upd_key
    logic signed [KeyW-1:0] upd_key;  // key of the item under work
  } cell_ctl_t;

  // Status handed from a cell to its neighbors and to the result logic.
  typedef struct packed {
    logic                   lt;       // stored key below the item key
    logic                   eq;       // stored key equals the item key
    logic                   gt;       // stored key above the item key
    logic signed [KeyW-1:0] key;      // stored key
  } cell_stat_t;

endpackage

// File: src/osse_cell.sv
// One cell of the sorted key chain: holds a key and shifts with its neighbors.
module osse_cell (
  input  logic                  clk_i,
  input  osse_pkg::cell_ctl_t   ctl_i,
  input  logic                  valid_i,
  input  logic                  left_lt_i,
  input  logic                  left_gt_i,
  input  logic [31:0]           left_key_i,
  input  logic                  right_lt_i,
  input  logic [31:0]           right_key_i,
  output osse_pkg::cell_stat_t  stat_o,
  output logic [31:0]           succ_key_o,
  output logic [31:0]           pred_key_o,
  output logic                  succ_hit_o,
  output logic                  pred_hit_o
);
  import osse_pkg::*;

  logic signed [KeyW-1:0] key_q;
  logic                   lt_q;
  logic                   eq_q;
  logic                   gt;

  // Compare flags are taken when an item is accepted and held while it is worked.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      lt_q <= valid_i && (key_q < ctl_i.cmp_key);
      eq_q <= valid_i && (key_q == ctl_i.cmp_key);
    end
  end

  assign gt = valid_i && !lt_q && !eq_q;

  // Insert shifts keys at or above the slot one cell up; delete pulls them down.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && !lt_q) begin
      key_q <= left_lt_i ? ctl_i.upd_key : $signed(left_key_i);
    end else if (ctl_i.del && !lt_q) begin
      key_q <= $signed(right_key_i);
    end
  end

  // The first cell above the key is the successor, the last below it the predecessor.
  assign succ_hit_o = gt && !left_gt_i;
  assign pred_hit_o = lt_q && !right_lt_i;
  assign succ_key_o = succ_hit_o ? key_q : '0;
  assign pred_key_o = pred_hit_o ? key_q : '0;

  assign stat_o.lt  = lt_q;
  assign stat_o.eq  = eq_q;
  assign stat_o.gt  = gt;
  assign stat_o.key = key_q;

endmodule

// File: src/ordered_set_successor_engine_unit.sv
// Top level of the ordered set successor engine: sequencer and row of key cells.
//
//   channel | signals                          | handshake
//   --------+----------------------------------+---------------------------------
//   item in | start_i, kind_i, key_i           | taken when start_i && !busy_o
//   result  | done_o, found_o, neighbor_o,     | one-cycle strobe on done_o,
//           | full_res_o                       | no back pressure
//
// An item is worked in steps: all cells compare the key in the accept cycle;
// in the cycle after, the one-hot neighbor select and the shift of the chain
// happen together, and done_o shows the result in the cycle after that.
// A new item can be accepted in the same cycle that done_o is high.
// Reset empties the set at once; stored keys past the fill count are ignored.
module ordered_set_successor_engine_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] key_i,
  output logic        busy_o,
  output logic        done_o,
  output logic        found_o,
  output logic [31:0] neighbor_o,
  output logic        full_res_o
);
  import osse_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                   busy_q;
  logic [2:0]             kind_q;
  logic signed [KeyW-1:0] key_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_d;
  logic                   done_q;
  logic                   found_q;
  logic                   found_d;
  logic [KeyW-1:0]        neighbor_q;
  logic [KeyW-1:0]        neighbor_d;
  logic                   full_q;
  logic                   full_d;

  cell_ctl_t              ctl;
  cell_stat_t             stat [CAPACITY];
  logic [KeyW-1:0]        succ_key [CAPACITY];
  logic [KeyW-1:0]        pred_key [CAPACITY];
  logic [CAPACITY-1:0]    succ_hit;
  logic [CAPACITY-1:0]    pred_hit;
  logic [CAPACITY-1:0]    eq_vec;
  logic [KeyW-1:0]        succ_any;
  logic [KeyW-1:0]        pred_any;
  logic                   present;
  logic                   accept;
  logic                   is_full;

  assign accept  = start_i && !busy_q;
  assign is_full = (count_q == CntW'(CAPACITY));

  // Row of cells; each sees its neighbors' flags and keys.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            left_lt;
    logic            left_gt;
    logic [KeyW-1:0] left_key;
    logic            right_lt;
    logic [KeyW-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_gt  = 1'b0;
      assign left_key = stat[i].key;
    end else begin : g_inner_l
      assign left_lt  = stat[i-1].lt;
      assign left_gt  = stat[i-1].gt;
      assign left_key = stat[i-1].key;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_lt  = 1'b0;
      assign right_key = stat[i].key;
    end else begin : g_inner_r
      assign right_lt  = stat[i+1].lt;
      assign right_key = stat[i+1].key;
    end

    osse_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (CntW'(i) < count_q),
      .left_lt_i   (left_lt),
      .left_gt_i   (left_gt),
      .left_key_i  (left_key),
      .right_lt_i  (right_lt),
      .right_key_i (right_key),
      .stat_o      (stat[i]),
      .succ_key_o  (succ_key[i]),
      .pred_key_o  (pred_key[i]),
      .succ_hit_o  (succ_hit[i]),
      .pred_hit_o  (pred_hit[i])
    );

    assign eq_vec[i] = stat[i].eq;
  end

  // Merge the one-hot neighbor selects of all cells.
  always_comb begin
    succ_any = '0;
    pred_any = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      succ_any = succ_any | succ_key[i];
      pred_any = pred_any | pred_key[i];
    end
  end

  assign present = |eq_vec;

  // Decode the operation of the item under work.
  always_comb begin
    ctl.capture = accept;
    ctl.cmp_key = $signed(key_i);
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    ctl.upd_key = key_q;
    count_d     = count_q;
    found_d     = 1'b0;
    neighbor_d  = '0;
    full_d      = 1'b0;
    if (busy_q) begin
      case (kind_e'(kind_q))
        KIND_INSERT: begin
          if (present) begin
            found_d = 1'b1;
          end else if (is_full) begin
            full_d = 1'b1;
          end else begin
            ctl.ins = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        KIND_DELETE: begin
          if (present) begin
            found_d = 1'b1;
            ctl.del = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
        KIND_EXISTS: begin
          found_d = present;
        end
        KIND_SUCC: begin
          found_d    = |succ_hit;
          neighbor_d = succ_any;
        end
        KIND_PRED: begin
          found_d    = |pred_hit;
          neighbor_d = pred_any;
        end
        default: begin
          found_d = 1'b0;
        end
      endcase
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= accept;
      done_q  <= busy_q;
      count_q <= count_d;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= $signed(key_i);
    end
    if (busy_q) begin
      found_q    <= found_d;
      neighbor_q <= neighbor_d;
      full_q     <= full_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign found_o    = found_q;
  assign neighbor_o = neighbor_q;
  assign full_res_o = full_q;

endmodule

// File: src/osse_checker.sv
// Port-level checker for the ordered set successor engine, bound to the top level.
module osse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        found_o,
  input logic [31:0] neighbor_o,
  input logic        full_res_o
);

  // An accepted item keeps the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // Each busy cycle is followed by a result strobe with busy low.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
    else $error("busy cycle not followed by a result");

  // A result is only shown after a busy cycle.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without an item");

  // A refused insert never reports the key as present.
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full_res_o) |-> !found_o)
    else $error("full and found together");

  // A nonzero neighbor only comes with a found result.
  a_neighbor_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (neighbor_o != '0)) |-> found_o)
    else $error("neighbor without found");

endmodule

bind ordered_set_successor_engine_unit osse_checker u_osse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .found_o    (found_o),
  .neighbor_o (neighbor_o),
  .full_res_o (full_res_o)
);

// File: tb/tb_top.sv
// Self-checking testbench for the ordered set successor engine: random and directed items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import osse_pkg::*;

  localparam int Capacity = 256;
  localparam int TailItems = 200;
  localparam int MaxReports = 10;
  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7fff_ffff;

  // Kind codes that the block treats as no operation.
  localparam logic [2:0] KindSpareA = 3'd5;
  localparam logic [2:0] KindSpareB = 3'd6;
  localparam logic [2:0] KindSpareC = 3'd7;

  typedef struct {
    logic [2:0]             kind;
    logic signed [KeyW-1:0] key;
    bit                     drain_first;  // wait until all results are back
  } op_item_t;

  typedef struct {
    logic                   found;
    logic signed [KeyW-1:0] neighbor;
    logic                   full_res;
  } op_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  kind_i  = '0;
  logic [31:0] key_i   = '0;
  logic        busy_o;
  logic        done_o;
  logic        found_o;
  logic [31:0] neighbor_o;
  logic        full_res_o;

  ordered_set_successor_engine_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .kind_i    (kind_i),
    .key_i     (key_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .found_o   (found_o),
    .neighbor_o(neighbor_o),
    .full_res_o(full_res_o)
  );

  always #5 clk_i = ~clk_i;

  op_item_t               pending_items[$];
  op_result_t             expected_results[$];
  logic signed [KeyW-1:0] set_keys[$];   // mirror of the stored set, ascending
  logic signed [KeyW-1:0] key_pool[$];   // keys handed to inserts and not yet picked for a delete
  int                     gap_left   = 0;
  int                     fail_count = 0;
  logic                   taken;
  op_item_t               next_item;
  op_result_t             want;

  // Apply one item to the mirrored set and return the result it must give.
  function automatic op_result_t apply_op(logic [2:0] kind, logic signed [KeyW-1:0] key);
    op_result_t res;
    int         pos;
    bit         present;
    res.found    = 1'b0;
    res.neighbor = '0;
    res.full_res = 1'b0;
    pos = 0;
    while (pos < set_keys.size() && set_keys[pos] < key) pos++;
    present = (pos < set_keys.size()) && (set_keys[pos] == key);
    case (kind)
      KIND_INSERT: begin
        if (present) begin
          res.found = 1'b1;
        end else if (set_keys.size() >= Capacity) begin
          res.full_res = 1'b1;
        end else begin
          set_keys.insert(pos, key);
        end
      end
      KIND_DELETE: begin
        if (present) begin
          res.found = 1'b1;
          set_keys.delete(pos);
        end
      end
      KIND_EXISTS: res.found = present;
      KIND_SUCC: begin
        if (present) pos++;
        if (pos < set_keys.size()) begin
          res.found    = 1'b1;
          res.neighbor = set_keys[pos];
        end
      end
      KIND_PRED: begin
        if (pos > 0) begin
          res.found    = 1'b1;
          res.neighbor = set_keys[pos-1];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Driver: predicts each accepted item and presents the next one.
  always @(posedge clk_i) begin
    taken = rst_ni && start_i && !busy_o;
    if (taken) begin
      expected_results.push_back(apply_op(kind_i, key_i));
      if (pending_items.size() >= TailItems && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 15);
      end
    end
    if (!rst_ni || (start_i && !taken)) begin
      // Keep the current item on the ports until it is taken.
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start_i <= 1'b0;
    end else if (pending_items.size() > 0 &&
                 !(pending_items[0].drain_first && expected_results.size() != 0)) begin
      next_item = pending_items.pop_front();
      kind_i  <= next_item.kind;
      key_i   <= next_item.key;
      start_i <= 1'b1;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("unexpected result: found=%0b neighbor=%0d full_res=%0b",
                   found_o, $signed(neighbor_o), full_res_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (found_o !== want.found || neighbor_o !== want.neighbor ||
            full_res_o !== want.full_res) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("mismatch: expected found=%0b neighbor=%0d full_res=%0b, got %0b %0d %0b",
                     want.found, want.neighbor, want.full_res,
                     found_o, $signed(neighbor_o), full_res_o);
          end
        end
      end
    end
  end

  task automatic add_item(logic [2:0] kind, logic signed [KeyW-1:0] key,
                          bit drain_first = 1'b0);
    op_item_t it;
    it.kind        = kind;
    it.key         = key;
    it.drain_first = drain_first;
    pending_items.push_back(it);
    if (kind == KIND_INSERT) key_pool.push_back(key);
  endtask

  // Choose a key: often a known one or a neighbor of it, sometimes an extreme.
  function automatic logic signed [KeyW-1:0] pick_key(int pool_pct, bit narrow, bit consume);
    int                     r;
    int                     idx;
    logic signed [KeyW-1:0] k;
    r = $urandom_range(0, 99);
    if (key_pool.size() > 0 && r < pool_pct) begin
      idx = $urandom_range(0, key_pool.size() - 1);
      k = key_pool[idx];
      if (consume) begin
        key_pool.delete(idx);
      end else begin
        case ($urandom_range(0, 3))
          0: k = k + 1;
          1: k = k - 1;
          default: ;
        endcase
      end
    end else if (r < pool_pct + 10) begin
      case ($urandom_range(0, 5))
        0: k = KeyMin;
        1: k = KeyMin + 1;
        2: k = KeyMax;
        3: k = KeyMax - 1;
        4: k = '0;
        default: k = -1;
      endcase
    end else if (narrow) begin
      k = int'($urandom_range(0, 40)) - 20;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // One random phase; its first item waits until the block has drained.
  task automatic gen_phase(int n, int ins_pct, int del_pct, int pool_pct, bit narrow);
    int                     i;
    int                     r;
    logic [2:0]             kind;
    logic signed [KeyW-1:0] key;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        kind = KIND_INSERT;
        key  = pick_key(pool_pct / 4, narrow, 1'b0);
      end else if (r < ins_pct + del_pct) begin
        kind = KIND_DELETE;
        key  = pick_key(pool_pct, narrow, 1'b1);
      end else if (r >= 97) begin
        kind = 3'($urandom_range(KindSpareA, KindSpareC));
        key  = $urandom;
      end else begin
        kind = 3'($urandom_range(KIND_EXISTS, KIND_PRED));
        key  = pick_key(pool_pct, narrow, 1'b0);
      end
      add_item(kind, key, i == 0);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    // Queries on the empty set.
    add_item(KIND_PRED, '0);
    add_item(KIND_SUCC, '0);
    add_item(KIND_EXISTS, '0);
    add_item(KIND_DELETE, 5);
    // Extremes and a few small keys, then a duplicate insert and membership checks.
    add_item(KIND_INSERT, KeyMin);
    add_item(KIND_INSERT, KeyMax);
    add_item(KIND_INSERT, '0);
    add_item(KIND_INSERT, -1);
    add_item(KIND_INSERT, 1);
    add_item(KIND_INSERT, '0);
    add_item(KIND_EXISTS, '0);
    add_item(KIND_EXISTS, 2);
    // No neighbor past the extremes; neighbors found around them.
    add_item(KIND_SUCC, KeyMax);
    add_item(KIND_PRED, KeyMin);
    add_item(KIND_SUCC, KeyMin);
    add_item(KIND_PRED, KeyMax);
    add_item(KIND_SUCC, -1);
    add_item(KIND_PRED, '0);
    add_item(KIND_SUCC, 5);
    add_item(KIND_PRED, -5);
    // Delete present and absent keys, then the unused kinds.
    add_item(KIND_DELETE, '0);
    add_item(KIND_DELETE, '0);
    add_item(KindSpareA, '1);
    add_item(KindSpareB, KeyMin);
    add_item(KindSpareC, KeyMax);

    // Fill past capacity, churn while full, drain, then work on a narrow key range.
    gen_phase(380, 75, 3, 40, 1'b0);
    gen_phase(350, 40, 8, 60, 1'b0);
    gen_phase(420, 5, 75, 85, 1'b0);
    gen_phase(600, 35, 30, 50, 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || start_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
